// ===== design/box_filter_3x3_rgb_defines.svh =====
// Assertion macros shared by the checker of the 3x3 box filter.
`ifndef BOX_FILTER_3X3_RGB_DEFINES_SVH
`define BOX_FILTER_3X3_RGB_DEFINES_SVH

// General property checked on every rising edge, quiet while reset is asserted.
`define BF3_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A result stalled by the consumer keeps its valid and its payload.
`define BF3_ASSERT_HOLD(lbl, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		out_valid && !out_ready |=> out_valid && $stable(sig)) \
		else $error("result changed while stalled");

`endif

// ===== design/bf3_pkg.sv =====
// Shared types, constants and helpers of the 3x3 RGB box filter.
package bf3_pkg;

	localparam int PIX_W             = 8;
	localparam int COORD_W           = 12;
	localparam int CFG_DATA_W        = 13;
	localparam int CFG_IDX_W         = 1;
	localparam int DEFAULT_MAX_WIDTH = 4096;
	localparam int MAX_HEIGHT        = 4096;
	localparam int RESET_WIDTH       = 640;
	localparam int RESET_HEIGHT      = 480;
	localparam int MIN_SIZE          = 3;
	localparam int OUT_DEPTH         = 4;

	// Sum of three 8-bit samples, and of nine.
	localparam int COLSUM_W = 10;
	localparam int SUM_W    = 12;

	// floor(x / 9) == (x * 3641) >> 15 for every x below 4096.
	localparam int DIV9_MUL   = 3641;
	localparam int DIV9_SHIFT = 15;
	localparam int PROD_W     = SUM_W + DIV9_SHIFT;

	localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		rgb_t older;
		rgb_t newer;
	} line_pair_t;

	typedef struct packed {
		logic               valid;
		logic               emit;
		logic               last;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} pix_ctl_t;

	typedef struct packed {
		rgb_t               mean;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               last;
	} result_t;

	function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] sum);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(sum) * PROD_W'(DIV9_MUL);
		return prod[DIV9_SHIFT +: PIX_W];
	endfunction

endpackage

// ===== design/bf3_line_mem.sv =====
// Line store holding the two previous rows side by side, with a registered read.
module bf3_line_mem #(
	parameter int DEPTH  = bf3_pkg::DEFAULT_MAX_WIDTH,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output bf3_pkg::line_pair_t rd_data_q,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  bf3_pkg::line_pair_t wr_data
);
	import bf3_pkg::*;

	line_pair_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule

// ===== design/bf3_window.sv =====
// Column sums, 3x3 window accumulation and divide-by-nine of the box filter.
module bf3_window (
	input  logic                clk,
	input  logic                arst_n,
	input  bf3_pkg::pix_ctl_t   ctl_s1,
	input  bf3_pkg::rgb_t       pix_s1,
	input  bf3_pkg::line_pair_t line_rd,
	output bf3_pkg::line_pair_t line_wr,
	output logic                push,
	output bf3_pkg::result_t    push_data
);
	import bf3_pkg::*;

	logic [2:0][PIX_W-1:0]    old_c, new_c, cur_c;
	logic [2:0][COLSUM_W-1:0] cs_cur;
	logic [2:0][COLSUM_W-1:0] cs_a_q, cs_b_q;
	logic [2:0][SUM_W-1:0]    sum_d, sum_s2;
	logic                     emit_s2;
	logic [COORD_W-1:0]       col_s2, row_s2;
	logic                     last_s2;

	assign old_c = line_rd.older;
	assign new_c = line_rd.newer;
	assign cur_c = pix_s1;

	// The row above moves down one line; the incoming pixel becomes the row above.
	assign line_wr = '{older: line_rd.newer, newer: pix_s1};

	// cs_a_q holds the column two back, cs_b_q the column one back.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			cs_cur[ch] = COLSUM_W'(old_c[ch]) + COLSUM_W'(new_c[ch]) + COLSUM_W'(cur_c[ch]);
			sum_d[ch]  = SUM_W'(cs_a_q[ch]) + SUM_W'(cs_b_q[ch]) + SUM_W'(cs_cur[ch]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			cs_a_q  <= cs_b_q;
			cs_b_q  <= cs_cur;
			sum_s2  <= sum_d;
			col_s2  <= ctl_s1.col;
			row_s2  <= ctl_s1.row;
			last_s2 <= ctl_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else begin
			emit_s2 <= ctl_s1.valid & ctl_s1.emit;
		end
	end

	assign push = emit_s2;

	always_comb begin
		push_data.mean.red   = div9(sum_s2[2]);
		push_data.mean.green = div9(sum_s2[1]);
		push_data.mean.blue  = div9(sum_s2[0]);
		push_data.col        = col_s2;
		push_data.row        = row_s2;
		push_data.last       = last_s2;
	end

endmodule

// ===== design/bf3_out_fifo.sv =====
// Small result queue that decouples the filter pipeline from the consumer.
module bf3_out_fifo #(
	parameter int DEPTH = bf3_pkg::OUT_DEPTH,
	parameter int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bf3_pkg::result_t push_data,
	input  logic             pop,
	output logic             valid,
	output bf3_pkg::result_t data,
	output logic [CNT_W-1:0] count
);
	import bf3_pkg::*;

	result_t          fifo_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign valid = (count_q != '0);
	assign data  = fifo_q[rd_ptr_q];
	assign count = count_q;

endmodule

// ===== design/box_filter_3x3_rgb.sv =====
// 3x3 box filter (mean of nine) over an RGB raster stream, top level.
//
// Pixels enter in raster order, one transfer per clock when the output side keeps up, and each
// interior pixel (not in the first or last row or column) leaves as the truncated mean of its
// 3x3 neighborhood per channel, with alpha 255, its own column and row, and a flag on the last
// interior pixel of the frame; border pixels give no result. Throughput, while in_ready is high,
// is one pixel per cycle: the line store is one memory holding both previous rows of a column
// in one word, read when a pixel is accepted and written back the next cycle, so each pixel
// costs one read and one write. A result passes through stage 1, the window stage and the
// output queue of OUT_DEPTH entries, and in_ready drops only when the queue plus the results
// still in flight could fill it. frame_width and frame_height are saturated to 3..MAX_WIDTH
// and 3..4096; they should be written only while the block is idle. After reset the line
// store is not cleared: the first two rows of a frame fill it before any result needs it, so
// the block accepts pixels from the first cycle on.
module box_filter_3x3_rgb #(
	parameter int MAX_WIDTH = bf3_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bf3_pkg::PIX_W-1:0]      red_in,
	input  logic [bf3_pkg::PIX_W-1:0]      green_in,
	input  logic [bf3_pkg::PIX_W-1:0]      blue_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [bf3_pkg::PIX_W-1:0]      red_out,
	output logic [bf3_pkg::PIX_W-1:0]      green_out,
	output logic [bf3_pkg::PIX_W-1:0]      blue_out,
	output logic [bf3_pkg::PIX_W-1:0]      alpha_out,
	output logic [bf3_pkg::COORD_W-1:0]    col_out,
	output logic [bf3_pkg::COORD_W-1:0]    row_out,
	output logic                           last_of_frame
);
	import bf3_pkg::*;

	localparam int CNT_W    = $clog2(MAX_WIDTH);
	localparam int EW_W     = CNT_W + 1;
	localparam int ROW_W    = COORD_W;
	localparam int EH_W     = COORD_W + 1;
	localparam int FCNT_W   = $clog2(OUT_DEPTH + 1);
	localparam int PEND_W   = $clog2(OUT_DEPTH + 3);
	// A pixel completes a window once two columns and two rows lie before it.
	localparam int WIN_LAG  = 2;

	logic [CFG_DATA_W-1:0] frame_width_q, frame_height_q;
	logic [EW_W-1:0]       eff_w;
	logic [EH_W-1:0]       eff_h;
	logic [CNT_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic [EW_W-1:0]       col_nx;
	logic [EH_W-1:0]       row_nx;
	logic                  accept;
	logic                  emit, last;
	logic [CNT_W-1:0]      col_m1;
	logic [ROW_W-1:0]      row_m1;

	pix_ctl_t              ctl_s1;
	rgb_t                  pix_s1;
	logic [CNT_W-1:0]      addr_s1;

	line_pair_t            line_rd, line_wr;
	logic                  push;
	result_t               push_data, out_data;
	logic [FCNT_W-1:0]     fifo_count;
	logic [PEND_W-1:0]     pending;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= CFG_DATA_W'(RESET_WIDTH);
			frame_height_q <= CFG_DATA_W'(RESET_HEIGHT);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
			endcase
		end
	end

	// Effective frame size, saturated to what the line store and the row counter can hold.
	always_comb begin
		priority if (frame_width_q < CFG_DATA_W'(MIN_SIZE)) begin
			eff_w = EW_W'(MIN_SIZE);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			eff_w = EW_W'(MAX_WIDTH);
		end else begin
			eff_w = EW_W'(frame_width_q);
		end
		priority if (frame_height_q < CFG_DATA_W'(MIN_SIZE)) begin
			eff_h = EH_W'(MIN_SIZE);
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = EH_W'(MAX_HEIGHT);
		end else begin
			eff_h = EH_W'(frame_height_q);
		end
	end

	// The counters give the position of the pixel on the input port. A size change takes effect
	// at once; past the new end, the column wraps to zero on the next transfer, the row with it.
	assign accept = in_valid & in_ready;
	assign col_nx = {1'b0, col_q} + EW_W'(1);
	assign row_nx = {1'b0, row_q} + EH_W'(1);

	assign emit = (row_q >= ROW_W'(WIN_LAG)) && (col_q >= CNT_W'(WIN_LAG))
		&& ({1'b0, row_q} < eff_h) && ({1'b0, col_q} < eff_w);
	assign last = ({1'b0, row_q} == eff_h - EH_W'(1)) && ({1'b0, col_q} == eff_w - EW_W'(1));

	// The window center sits one column left of and one row above the incoming pixel.
	assign col_m1 = col_q - CNT_W'(1);
	assign row_m1 = row_q - ROW_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_nx >= eff_w) begin
				col_q <= '0;
				row_q <= (row_nx >= eff_h) ? '0 : row_nx[ROW_W-1:0];
			end else begin
				col_q <= col_nx[CNT_W-1:0];
			end
		end
	end

	// Stage 1: the pixel waits here while the line store returns its column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			if (accept) begin
				ctl_s1.emit <= emit;
				ctl_s1.last <= last;
				ctl_s1.col  <= COORD_W'(col_m1);
				ctl_s1.row  <= row_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= '{red: red_in, green: green_in, blue: blue_in};
			addr_s1 <= col_q;
		end
	end

	// Read on transfer, write back in the cycle after. The column always changes between
	// consecutive pixels (frame width is at least three), so the write of one pixel never hits
	// the address read for the next and no forwarding path is needed.
	bf3_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (CNT_W)
	) u_line_mem (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (col_q),
		.rd_data_q (line_rd),
		.wr_en     (ctl_s1.valid),
		.wr_addr   (addr_s1),
		.wr_data   (line_wr)
	);

	bf3_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.pix_s1    (pix_s1),
		.line_rd   (line_rd),
		.line_wr   (line_wr),
		.push      (push),
		.push_data (push_data)
	);

	bf3_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (out_valid & out_ready),
		.valid     (out_valid),
		.data      (out_data),
		.count     (fifo_count)
	);

	// Accept only while the queue has room for every result that could still arrive,
	// including one from the pixel accepted in this cycle.
	assign pending = PEND_W'(fifo_count) + PEND_W'(ctl_s1.valid & ctl_s1.emit) + PEND_W'(push);
	assign in_ready = (pending < PEND_W'(OUT_DEPTH));

	assign red_out       = out_data.mean.red;
	assign green_out     = out_data.mean.green;
	assign blue_out      = out_data.mean.blue;
	assign alpha_out     = ALPHA_OPAQUE;
	assign col_out       = out_data.col;
	assign row_out       = out_data.row;
	assign last_of_frame = out_data.last;

endmodule

// ===== design/bf3_checker.sv =====
// Port-level checker of the 3x3 box filter, bound to its top level.
`include "box_filter_3x3_rgb_defines.svh"

module bf3_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [bf3_pkg::PIX_W-1:0]   red_out,
	input logic [bf3_pkg::PIX_W-1:0]   green_out,
	input logic [bf3_pkg::PIX_W-1:0]   blue_out,
	input logic [bf3_pkg::PIX_W-1:0]   alpha_out,
	input logic [bf3_pkg::COORD_W-1:0] col_out,
	input logic [bf3_pkg::COORD_W-1:0] row_out,
	input logic                        last_of_frame
);
	import bf3_pkg::*;

	logic [4*PIX_W+2*COORD_W:0] payload;

	assign payload = {red_out, green_out, blue_out, alpha_out, col_out, row_out, last_of_frame};

	// A new result shows up only after the transfer of a pixel.
	`BF3_ASSERT(a_result_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 3), "result without a pixel three cycles before")
	// Input backpressure only ever comes with a result waiting in the queue.
	`BF3_ASSERT(a_ready_backpressure, !in_ready |-> out_valid, "input stalled with no result pending")
	// Alpha is constant on every result.
	`BF3_ASSERT(a_alpha_opaque, out_valid |-> alpha_out == ALPHA_OPAQUE, "alpha is not opaque")
	`BF3_ASSERT_HOLD(a_result_hold, payload)

endmodule

bind box_filter_3x3_rgb bf3_checker u_bf3_checker (.*);

// ===== bench/box_filter_3x3_rgb_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard of the 3x3 RGB box filter: mirrors the filter state, predicts and compares results.
module box_filter_3x3_rgb_checker #(
	parameter int MAX_WIDTH = bf3_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [bf3_pkg::PIX_W-1:0]      red_in,
	input  logic [bf3_pkg::PIX_W-1:0]      green_in,
	input  logic [bf3_pkg::PIX_W-1:0]      blue_in,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [bf3_pkg::PIX_W-1:0]      red_out,
	input  logic [bf3_pkg::PIX_W-1:0]      green_out,
	input  logic [bf3_pkg::PIX_W-1:0]      blue_out,
	input  logic [bf3_pkg::PIX_W-1:0]      alpha_out,
	input  logic [bf3_pkg::COORD_W-1:0]    col_out,
	input  logic [bf3_pkg::COORD_W-1:0]    row_out,
	input  logic                           last_of_frame,
	output int                             pending_results,
	output int                             mismatch_count
);
	import bf3_pkg::*;

	rgb_t                  older_line [MAX_WIDTH];
	rgb_t                  newer_line [MAX_WIDTH];
	rgb_t                  window_cols [6];
	logic [COORD_W-1:0]    next_col;
	logic [COORD_W-1:0]    next_row;
	logic [CFG_DATA_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0] height_reg;
	result_t               expected_means [$];

	function automatic int clamp_size(input int v, input int hi);
		if (v < MIN_SIZE) begin
			return MIN_SIZE;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// Runs one accepted pixel through the mirrored filter state.
	task automatic absorb_pixel(input rgb_t px);
		int               w;
		int               h;
		int               col;
		int               row;
		int               idx;
		rgb_t             column_now [3];
		logic [SUM_W-1:0] sum_r;
		logic [SUM_W-1:0] sum_g;
		logic [SUM_W-1:0] sum_b;
		result_t          res;
		w = clamp_size(width_reg, MAX_WIDTH);
		h = clamp_size(height_reg, MAX_HEIGHT);
		col = next_col;
		row = next_row;
		idx = col % MAX_WIDTH;
		column_now[0] = older_line[idx];
		column_now[1] = newer_line[idx];
		column_now[2] = px;
		if (row >= 2 && col >= 2 && row < h && col < w) begin
			sum_r = '0;
			sum_g = '0;
			sum_b = '0;
			for (int k = 0; k < 6; k++) begin
				sum_r += window_cols[k].red;
				sum_g += window_cols[k].green;
				sum_b += window_cols[k].blue;
			end
			for (int k = 0; k < 3; k++) begin
				sum_r += column_now[k].red;
				sum_g += column_now[k].green;
				sum_b += column_now[k].blue;
			end
			res.mean.red = sum_r / 9;
			res.mean.green = sum_g / 9;
			res.mean.blue = sum_b / 9;
			res.col = col - 1;
			res.row = row - 1;
			res.last = (row == h - 1) && (col == w - 1);
			expected_means.push_back(res);
		end
		older_line[idx] = newer_line[idx];
		newer_line[idx] = px;
		for (int k = 0; k < 3; k++) begin
			window_cols[k] = window_cols[k + 3];
			window_cols[k + 3] = column_now[k];
		end
		if (col + 1 >= w) begin
			next_col = '0;
			next_row = (row + 1 >= h) ? '0 : row + 1;
		end else begin
			next_col = col + 1;
		end
	endtask

	task automatic check_result();
		result_t got;
		result_t want;
		got.mean.red = red_out;
		got.mean.green = green_out;
		got.mean.blue = blue_out;
		got.col = col_out;
		got.row = row_out;
		got.last = last_of_frame;
		if (expected_means.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("%0t: result with none outstanding: rgb %0d %0d %0d col %0d row %0d last %0d",
					$realtime, red_out, green_out, blue_out, col_out, row_out, last_of_frame);
			end
			return;
		end
		want = expected_means.pop_front();
		if (got.mean.red != want.mean.red || got.mean.green != want.mean.green ||
				got.mean.blue != want.mean.blue || alpha_out != ALPHA_OPAQUE ||
				got.col != want.col || got.row != want.row || got.last != want.last) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("%0t: mismatch: want rgba %0d %0d %0d %0d col %0d row %0d last %0d",
					$realtime, want.mean.red, want.mean.green, want.mean.blue, ALPHA_OPAQUE,
					want.col, want.row, want.last);
				$display("%0t:           got  rgba %0d %0d %0d %0d col %0d row %0d last %0d",
					$realtime, red_out, green_out, blue_out, alpha_out, col_out, row_out,
					last_of_frame);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				older_line[i] = '0;
				newer_line[i] = '0;
			end
			for (int k = 0; k < 6; k++) begin
				window_cols[k] = '0;
			end
			next_col = '0;
			next_row = '0;
			width_reg = RESET_WIDTH;
			height_reg = RESET_HEIGHT;
			expected_means.delete();
			mismatch_count = 0;
			pending_results <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FRAME_WIDTH) begin
					width_reg = cfg_data;
				end else if (cfg_index == CFG_FRAME_HEIGHT) begin
					height_reg = cfg_data;
				end
			end
			if (in_valid && in_ready) begin
				absorb_pixel({red_in, green_in, blue_in});
			end
			if (out_valid && out_ready) begin
				check_result();
			end
			pending_results <= expected_means.size();
		end
	end

endmodule

// ===== bench/box_filter_3x3_rgb_test.sv =====
`timescale 1ns / 100ps
// Top of the 3x3 RGB box filter testbench: clock, reset, stimulus and the verdict.
module box_filter_3x3_rgb_test;
	import bf3_pkg::*;

	// The run is bounded generously; the slowest legal run is far below this.
	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASE_ITEMS   = 250;
	localparam int SETTLE_CYCLES = 8;
	localparam int WHOLE_FRAME   = 300;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [PIX_W-1:0]      red_in = '0;
	logic [PIX_W-1:0]      green_in = '0;
	logic [PIX_W-1:0]      blue_in = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [PIX_W-1:0]      red_out;
	logic [PIX_W-1:0]      green_out;
	logic [PIX_W-1:0]      blue_out;
	logic [PIX_W-1:0]      alpha_out;
	logic [COORD_W-1:0]    col_out;
	logic [COORD_W-1:0]    row_out;
	logic                  last_of_frame;

	int pending_results;
	int mismatch_count;
	int cycle_count = 0;

	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int send_idle_pct = 18;
	int recv_idle_pct = 52;

	// Stimulus-side view of the frame: the raw width register value, the sizes the registers
	// saturate to, where the next pixel lands, and how many line store columns have been
	// written at least once and at least twice so far. A column holds two defined rows only
	// after its second write, which decides which widths are safe to switch to in the middle
	// of a frame.
	logic [CFG_DATA_W-1:0] width_val = RESET_WIDTH;
	int eff_w = RESET_WIDTH;
	int eff_h = RESET_HEIGHT;
	int frame_col = 0;
	int frame_row = 0;
	int cols_written = 0;
	int cols_twice = 0;

	box_filter_3x3_rgb i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.red_in        (red_in),
		.green_in      (green_in),
		.blue_in       (blue_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.red_out       (red_out),
		.green_out     (green_out),
		.blue_out      (blue_out),
		.alpha_out     (alpha_out),
		.col_out       (col_out),
		.row_out       (row_out),
		.last_of_frame (last_of_frame)
	);

	box_filter_3x3_rgb_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.red_in          (red_in),
		.green_in        (green_in),
		.blue_in         (blue_in),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.red_out         (red_out),
		.green_out       (green_out),
		.blue_out        (blue_out),
		.alpha_out       (alpha_out),
		.col_out         (col_out),
		.row_out         (row_out),
		.last_of_frame   (last_of_frame),
		.pending_results (pending_results),
		.mismatch_count  (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The receiver decides afresh every cycle whether it takes a result.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: a hang, or a result that never shows up, ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int clamp_size(input int v, input int hi);
		if (v < MIN_SIZE) begin
			return MIN_SIZE;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	// One pixel transfer. Random idle cycles come first with valid low; once valid is raised
	// it stays up with the same payload until the filter takes the pixel. Valid is not
	// lowered after the transfer, so back-to-back pixels keep it high without a glitch.
	task automatic send_pixel(input rgb_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		red_in <= px.red;
		green_in <= px.green;
		blue_in <= px.blue;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		// Every row starts at column zero, so the columns written once or twice form a prefix.
		if (frame_col + 1 > cols_written) begin
			cols_written = frame_col + 1;
		end else if (frame_col + 1 > cols_twice) begin
			cols_twice = frame_col + 1;
		end
		if (frame_col + 1 >= eff_w) begin
			frame_col = 0;
			frame_row = (frame_row + 1 >= eff_h) ? 0 : frame_row + 1;
		end else begin
			frame_col++;
		end
	endtask

	// Drains the filter: stop sending, wait for every predicted result, then give pixels
	// that produce no result (borders) time to leave the pipeline as well.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both size registers are rewritten on every change, always from an idle filter.
	task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		width_val = w;
		eff_w = clamp_size(w, DEFAULT_MAX_WIDTH);
		eff_h = clamp_size(h, MAX_HEIGHT);
	endtask

	// Pixel flavors: full range, bright (sums near the top), dark, and hard extremes.
	function automatic logic [PIX_W-1:0] draw_channel(input int style);
		case (style)
			1: return $urandom_range(224, 255);
			2: return $urandom_range(0, 31);
			3: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// Sizes at a frame start: mostly small, now and then saturating at either end.
	function automatic logic [CFG_DATA_W-1:0] draw_width();
		int r;
		r = $urandom_range(99);
		if (r < 3) begin
			return $urandom_range(0, 2);
		end
		if (r < 6) begin
			return $urandom_range(DEFAULT_MAX_WIDTH, 8191);
		end
		if (r < 76) begin
			return $urandom_range(3, 10);
		end
		return $urandom_range(11, 48);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] draw_height();
		int r;
		r = $urandom_range(99);
		if (r < 3) begin
			return $urandom_range(0, 2);
		end
		if (r < 6) begin
			return $urandom_range(MAX_HEIGHT, 8191);
		end
		if (r < 80) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(9, 16);
	endfunction

	// A width change inside a frame must not make the filter read a line store column that
	// does not yet hold two written rows, so it only goes as wide as the columns filled twice.
	function automatic logic [CFG_DATA_W-1:0] mid_frame_width();
		int hi;
		if (cols_twice < MIN_SIZE) begin
			return width_val;
		end
		if ($urandom_range(9) == 0) begin
			return $urandom_range(0, 2);
		end
		hi = (cols_twice < 24) ? cols_twice : 24;
		return $urandom_range(MIN_SIZE, hi);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] mid_frame_height();
		if ($urandom_range(9) == 0) begin
			return $urandom_range(0, 2);
		end
		return $urandom_range(3, 12);
	endfunction

	// Random traffic. Most bursts run a small frame to its end so the last-of-frame flag and
	// the wrap to the next frame get exercised; some stop part way through, and then the sizes may
	// change under the running frame, always so for an oversized one, which cuts it short. A counter left
	// beyond the new size then has to wrap on its next step.
	task automatic run_random(input int target);
		int sent;
		int cap;
		int style;
		sent = 0;
		while (sent < target) begin
			if (frame_col == 0 && frame_row == 0 && $urandom_range(2) != 0) begin
				set_frame(draw_width(), draw_height());
			end
			style = $urandom_range(3);
			if (eff_w * eff_h <= WHOLE_FRAME && $urandom_range(6) != 0) begin
				cap = WHOLE_FRAME + 100;
			end else begin
				cap = $urandom_range(1, 80);
			end
			for (int k = 0; k < cap; k++) begin
				send_pixel({draw_channel(style), draw_channel(style), draw_channel(style)});
				sent++;
				if (frame_col == 0 && frame_row == 0) begin
					break;
				end
			end
			if (!(frame_col == 0 && frame_row == 0) &&
					(eff_w * eff_h > WHOLE_FRAME || $urandom_range(1) == 0)) begin
				set_frame(mid_frame_width(), mid_frame_height());
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sizes below the minimum saturate to a 3x3 frame with a single interior pixel.
		// First every channel at full scale, which gives the largest possible sums.
		set_frame(0, 2);
		for (int k = 0; k < 9; k++) begin
			send_pixel({8'hFF, 8'hFF, 8'hFF});
		end
		// Then red all zero, green all full, blue alternating between the two extremes.
		for (int k = 0; k < 9; k++) begin
			send_pixel({8'h00, 8'hFF, (k % 2 != 0) ? 8'hFF : 8'h00});
		end

		// Oversized frame (height saturates at the maximum), cut short in the second row:
		// the width drops to the current column and the height below nothing yet seen,
		// so the next pixel wraps the column, and the third row finishes a 3x3 frame.
		set_frame(5, 8191);
		for (int k = 0; k < 8; k++) begin
			send_pixel({draw_channel(0), draw_channel(0), draw_channel(0)});
		end
		set_frame(3, 1);
		for (int k = 0; k < 4; k++) begin
			send_pixel({draw_channel(0), draw_channel(0), draw_channel(0)});
		end

		// Random part in three handshake regimes: sender mostly busy while the receiver
		// stalls often, the reverse, and finally both sides at full rate.
		send_idle_pct = 18;
		recv_idle_pct = 52;
		run_random(PHASE_ITEMS);
		send_idle_pct = 52;
		recv_idle_pct = 18;
		run_random(PHASE_ITEMS);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(PHASE_ITEMS);

		settle();
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
